>>> rtl/core/kcms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcms_pkg
// Shared types, character constants and controller/datapath signal groups
// for the least-frequent k-mer seed selector.
// ----------------------------------------------------------------------------
package kcms_pkg;

   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   localparam logic FUNC_COUNT = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam int POSITION_WIDTH = 16;
   localparam int COUNT_WIDTH    = 32;

   typedef struct packed {
      logic       func;
      logic [7:0] base;
      logic       first;
      logic       last;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic [POSITION_WIDTH-1:0] min_position;
      logic [COUNT_WIDTH-1:0]    min_count;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;
      logic take;
      logic exec;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic emit_needed;
      logic rsp_blocked;
   } sts_type;

   function automatic logic [1:0] base_code(input logic [7:0] ch);
      logic [1:0] code;
      case (ch)
         CHAR_C:  code = CODE_C;
         CHAR_G:  code = CODE_G;
         CHAR_T:  code = CODE_T;
         default: code = CODE_A;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/kmer_count_min_seed_select.sv
`default_nettype none
// A character is taken in the idle state and executed in the execute state,
//   which holds while a result is due and the output register is full; a
//   query result is registered as it executes. No character is taken before
//   the last is executed: the count table is read on accept, updated on execute.
// Reset: control state clears at once, then a clearing pass zeroes all
//   4**KMER_LEN count table entries; req_stall stays high until it completes.
// ----------------------------------------------------------------------------
// kmer_count_min_seed_select
// Counts reference k-mers and selects the least frequent k-mer of a pattern.
// ----------------------------------------------------------------------------
module kmer_count_min_seed_select
   import kcms_pkg::*;
#(
   parameter int KMER_LEN   = 8,
   parameter int COUNT_BITS = 32,
   parameter int POS_BITS   = 16
) (
   input  wire      clock,
   input  wire      reset,
   input  wire      req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     rsp_valid,
   input  wire      rsp_stall,
   output rsp_type  rsp_data
);

   cmd_type cmd;
   sts_type sts;

   kcms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kcms_dp #(
      .KMER_LEN   (KMER_LEN),
      .COUNT_BITS (COUNT_BITS),
      .POS_BITS   (POS_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // no transfer in while the table is being cleared
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> req_stall)
      else $error("input taken during table clear");

   // a result only appears after an executed query with last set
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.exec && sts.emit_needed))
      else $error("result appeared without a finishing query");

   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && sts.emit_needed) |-> !sts.rsp_blocked)
      else $error("result register overwritten");

   // every accepted character is executed before the next is taken
   a_take_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> !cmd.take)
      else $error("character taken while another is in execution");

endmodule
`default_nettype wire

>>> rtl/core/kcms_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcms_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module kcms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/kcms_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcms_ctrl
// Sequencer: table clearing pass after reset, then accept one character,
// execute it against the count table, and return for the next.
// ----------------------------------------------------------------------------
module kcms_ctrl
   import kcms_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      req_valid,
   output logic     req_stall,
   input  sts_type  sts,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.clear_step = 1'b0;
      cmd.take       = 1'b0;
      cmd.exec       = 1'b0;
      req_stall      = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold while a result is due and the output register is still full
            if (!(sts.emit_needed && sts.rsp_blocked)) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/kcms_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcms_dp
// Datapath: k-mer window, count table, running minimum and result register.
// ----------------------------------------------------------------------------
module kcms_dp
   import kcms_pkg::*;
#(
   parameter int KMER_LEN   = 8,
   parameter int COUNT_BITS = 32,
   parameter int POS_BITS   = 16
) (
   input  wire      clock,
   input  wire      reset,
   input  req_type  req_data,
   output rsp_type  rsp_data,
   output logic     rsp_valid,
   input  wire      rsp_stall,
   input  cmd_type  cmd,
   output sts_type  sts
);

   localparam int ADDR_BITS = 2 * KMER_LEN;
   localparam int DEPTH     = 1 << ADDR_BITS;
   localparam int FILL_BITS = $clog2(KMER_LEN + 1);
   localparam int CPOS_BITS = POS_BITS + 1;

   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(KMER_LEN);
   localparam logic [CPOS_BITS-1:0] KMER_SPAN = CPOS_BITS'(KMER_LEN - 1);

   logic [ADDR_BITS-1:0]  clr_addr_ff;
   logic [ADDR_BITS-1:0]  window_ff, window_in, window_base;
   logic [FILL_BITS-1:0]  fill_ff, fill_in, fill_base;
   logic [CPOS_BITS-1:0]  cpos_ff, cpos_in;
   logic [COUNT_BITS-1:0] best_count_ff, best_count_in;
   logic [POS_BITS-1:0]   best_pos_ff, best_pos_in;
   logic                  best_valid_ff, best_valid_in;
   logic                  func_ff, last_ff, full_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [COUNT_BITS-1:0] cnt;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [CPOS_BITS-1:0]  start;
   logic                  take_best;
   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;

   // ---- accept: apply sequence start, shift window
   always_comb begin
      window_base = req_data.first ? '0 : window_ff;
      fill_base   = req_data.first ? '0 : fill_ff;
      window_in   = {window_base[ADDR_BITS-3:0], base_code(req_data.base)};
      fill_in     = (fill_base == FILL_FULL) ? fill_base : fill_base + FILL_BITS'(1);
   end

   // ---- execute: update count or running minimum
   always_comb begin
      cnt_inc   = (&cnt) ? cnt : cnt + COUNT_BITS'(1);
      start     = cpos_ff - KMER_SPAN;
      take_best = full_ff && (func_ff == FUNC_QUERY) && (!best_valid_ff || cnt < best_count_ff);

      best_valid_in = best_valid_ff;
      best_count_in = best_count_ff;
      best_pos_in   = best_pos_ff;
      if (take_best) begin
         best_valid_in = 1'b1;
         best_count_in = cnt;
         best_pos_in   = start[CPOS_BITS-1] ? '1 : start[POS_BITS-1:0];
      end
      cpos_in = (&cpos_ff) ? cpos_ff : cpos_ff + CPOS_BITS'(1);

      ram_we    = cmd.clear_step || (cmd.exec && full_ff && (func_ff == FUNC_COUNT));
      ram_waddr = cmd.clear_step ? clr_addr_ff : window_ff;
      ram_wdata = cmd.clear_step ? '0 : cnt_inc;
   end

   kcms_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.take),
      .rd_addr (window_in),
      .rd_data (cnt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         func_ff <= req_data.func;
         last_ff <= req_data.last;
         full_ff <= (fill_in == FILL_FULL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         fill_ff       <= '0;
         cpos_ff       <= '0;
         best_count_ff <= '1;
         best_pos_ff   <= '0;
         best_valid_ff <= 1'b0;
      end else if (cmd.take) begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
         if (req_data.first) begin
            cpos_ff       <= '0;
            best_count_ff <= '1;
            best_pos_ff   <= '0;
            best_valid_ff <= 1'b0;
         end
      end else if (cmd.exec) begin
         if (last_ff) begin
            // sequence ends: start afresh with the next character
            window_ff     <= '0;
            fill_ff       <= '0;
            cpos_ff       <= '0;
            best_count_ff <= '1;
            best_pos_ff   <= '0;
            best_valid_ff <= 1'b0;
         end else begin
            cpos_ff       <= cpos_in;
            best_count_ff <= best_count_in;
            best_pos_ff   <= best_pos_in;
            best_valid_ff <= best_valid_in;
         end
      end
   end

   // ---- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec && sts.emit_needed) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && sts.emit_needed) begin
         rsp_ff.found        <= best_valid_in;
         rsp_ff.min_position <= best_valid_in ? POSITION_WIDTH'(best_pos_in) : '0;
         rsp_ff.min_count    <= best_valid_in ? COUNT_WIDTH'(best_count_in) : '0;
      end
   end

   assign sts.clear_last  = &clr_addr_ff;
   assign sts.emit_needed = last_ff && (func_ff == FUNC_QUERY);
   assign sts.rsp_blocked = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> tb/kmer_count_min_seed_select_tb.sv
// ----------------------------------------------------------------------------
// kmer_count_min_seed_select_tb
// Streams reference and pattern characters into the seed selector, keeps its
// own k-mer count table and running minimum, and checks every seed result
// against that prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module kmer_count_min_seed_select_tb
   import kcms_pkg::*;
();

   localparam int KLEN = 8;
   localparam int DEPTH = 1 << (2 * KLEN);
   localparam int unsigned POS_TOP = (1 << POSITION_WIDTH) - 1;
   localparam int unsigned CHARPOS_TOP = (1 << (POSITION_WIDTH + 1)) - 1;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam int GENOME_LEN = 96;
   localparam int RANDOM_ITEMS = 1900;
   localparam int QUIET_FROM = 1600;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT = 300000;

   class seed_scoreboard;
      logic [COUNT_WIDTH-1:0]    tally [DEPTH];
      logic [2*KLEN-1:0]         window;
      int unsigned               fill;
      int unsigned               pos_next;
      logic [COUNT_WIDTH-1:0]    best_count;
      logic [POSITION_WIDTH-1:0] best_pos;
      bit                        best_seen;
      rsp_type                   expected_seeds [$];
      int                        errors;

      function new();
         foreach (tally[i]) tally[i] = '0;
         errors = 0;
         restart();
      endfunction

      function void restart();
         window = '0;
         fill = 0;
         pos_next = 0;
         best_count = '1;
         best_pos = '0;
         best_seen = 1'b0;
      endfunction

      function void note_char(req_type r);
         logic [1:0]             code;
         logic [COUNT_WIDTH-1:0] c;
         int unsigned            start;
         rsp_type                seed;
         if (r.first) restart();
         case (r.base)
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default: code = CODE_A;
         endcase
         window = {window[2*KLEN-3:0], code};
         if (fill < KLEN) fill++;
         if (fill >= KLEN) begin
            if (r.func == FUNC_COUNT) begin
               if (tally[window] != '1) tally[window] = tally[window] + 1'b1;
            end else begin
               c = tally[window];
               if (!best_seen || c < best_count) begin
                  start = pos_next + 1 - KLEN;
                  best_count = c;
                  best_pos = (start > POS_TOP) ? POSITION_WIDTH'(POS_TOP)
                                               : POSITION_WIDTH'(start);
                  best_seen = 1'b1;
               end
            end
         end
         if (pos_next < CHARPOS_TOP) pos_next++;
         if (r.last) begin
            if (r.func == FUNC_QUERY) begin
               seed.found = best_seen;
               seed.min_position = best_seen ? best_pos : '0;
               seed.min_count = best_seen ? best_count : '0;
               expected_seeds.push_back(seed);
            end
            restart();
         end
      endfunction

      task flag_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_seeds.size() == 0) begin
            flag_mismatch($sformatf("result with none pending: found %0d pos %0d count %0d",
                                    got.found, got.min_position, got.min_count));
         end else begin
            want = expected_seeds.pop_front();
            if (got.found !== want.found)
               flag_mismatch($sformatf("found got %0d expected %0d", got.found, want.found));
            if (got.min_position !== want.min_position)
               flag_mismatch($sformatf("min_position got %0d expected %0d",
                                       got.min_position, want.min_position));
            if (got.min_count !== want.min_count)
               flag_mismatch($sformatf("min_count got %0d expected %0d",
                                       got.min_count, want.min_count));
         end
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   seed_scoreboard sb = new();
   logic [7:0]     genome [GENOME_LEN];
   bit             quiet;
   bit             random_phase;
   bit             held;
   int             sent;
   int             idle_cycles;

   kmer_count_min_seed_select dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic req_type make_char(logic fn, logic [7:0] ch, logic fst, logic lst);
      req_type r;
      r.func = fn;
      r.base = ch;
      r.first = fst;
      r.last = lst;
      return r;
   endfunction

   function automatic logic [7:0] pick_letter();
      logic [7:0] ch;
      case ($urandom_range(0, 3))
         0:       ch = CHAR_A;
         1:       ch = CHAR_C;
         2:       ch = CHAR_G;
         default: ch = CHAR_T;
      endcase
      return ch;
   endfunction

   // Entered just after a falling edge; leaves just after a falling edge.
   task automatic send_char(req_type r);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_char(r);
      @(negedge clock);
   endtask

   task automatic send_text(logic fn, string s, bit fst, bit lst);
      for (int i = 0; i < s.len(); i++)
         send_char(make_char(fn, s[i], fst && i == 0, lst && i == s.len() - 1));
   endtask

   // Mostly substrings of a small genome, so counts repeat and minima move about.
   task automatic send_random_sequence();
      int         kind;
      int         len;
      int         at;
      bit         drop_first;
      bit         drop_last;
      logic       fn;
      logic [7:0] ch;
      logic       fst;
      logic       lst;
      kind = $urandom_range(0, 9);
      len = (kind == 9) ? $urandom_range(1, 6) : $urandom_range(1, 24);
      at = $urandom_range(0, GENOME_LEN - 1);
      drop_first = ($urandom_range(0, 9) == 0);
      drop_last = ($urandom_range(0, 9) == 0);
      fn = (kind < 4) ? FUNC_COUNT : FUNC_QUERY;
      for (int i = 0; i < len; i++) begin
         ch = genome[(at + i) % GENOME_LEN];
         if (kind >= 4 && kind < 8 && $urandom_range(0, 9) == 0)
            ch = ($urandom_range(0, 2) == 0) ? 8'($urandom) : pick_letter();
         if (kind == 8) fn = 1'($urandom_range(0, 1));
         fst = (i == 0) && !drop_first;
         lst = (i == len - 1) && !drop_last;
         if (kind == 9) begin
            fn = 1'($urandom_range(0, 1));
            ch = 8'($urandom);
            fst = 1'($urandom_range(0, 1));
            lst = 1'($urandom_range(0, 1));
         end
         send_char(make_char(fn, ch, fst, lst));
         sent++;
      end
   endtask

   // Receiver: short random stalls, one long hold-off early in the random part.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (random_phase && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // Watchdog: the clearing pass after reset is the longest legitimate silence.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** kmer_count_min_seed_select: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      quiet = 1'b0;
      random_phase = 1'b0;
      held = 1'b0;
      sent = 0;
      idle_cycles = 0;
      foreach (genome[i]) genome[i] = pick_letter();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reference with other bytes that code as A, then a pattern too short
      // for a window, a pattern whose minimum lies past the first window,
      // a lone count character ending a sequence, and an empty query.
      send_text(FUNC_COUNT, "CGT\377", 1'b1, 1'b0);
      send_char(make_char(FUNC_COUNT, 8'h00, 1'b0, 1'b0));
      send_text(FUNC_COUNT, "CGTA", 1'b0, 1'b1);
      send_text(FUNC_QUERY, "CGT", 1'b1, 1'b1);
      send_text(FUNC_QUERY, "CGTaACGTAG", 1'b1, 1'b1);
      send_char(make_char(FUNC_COUNT, CHAR_C, 1'b1, 1'b1));
      send_char(make_char(FUNC_QUERY, CHAR_G, 1'b0, 1'b1));

      random_phase = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= QUIET_FROM) quiet = 1'b1;
         send_random_sequence();
      end
      quiet = 1'b1;
      req_valid <= 1'b0;

      while (sb.expected_seeds.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("** kmer_count_min_seed_select: PASSED **");
      end else begin
         $display("** kmer_count_min_seed_select: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/kcms_pkg.sv
rtl/core/kcms_ram.sv
rtl/core/kcms_ctrl.sv
rtl/core/kcms_dp.sv
rtl/core/kmer_count_min_seed_select.sv
tb/kmer_count_min_seed_select_tb.sv
